// ===== rtl/core/led_buzzer_pattern_sequencer_assert.svh =====
// Assertion macros for the LED and buzzer pattern sequencer.
`ifndef LED_BUZZER_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_BUZZER_PATTERN_SEQUENCER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LBPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lbps assertion failed");
`define LBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lbps assertion failed");
`else
`define LBPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/lbps_pkg.sv =====
// Package: types and constants of the LED and buzzer pattern sequencer.
package lbps_pkg;

	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned COUNT_W  = 6;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 5;

	localparam logic [PERIOD_W-1:0] ELAPSED_MAX = '1;

	localparam logic [PERIOD_W-1:0] RST_IDENTIFY_PERIOD  = 16'd150;
	localparam logic [COUNT_W-1:0]  RST_IDENTIFY_TOGGLES = 6'd30;
	localparam logic [PERIOD_W-1:0] RST_DISPATCH_PERIOD  = 16'd80;
	localparam logic [COUNT_W-1:0]  RST_DISPATCH_TOGGLES = 6'd8;
	localparam logic [PERIOD_W-1:0] RST_ALARM_PERIOD     = 16'd120;

	typedef enum logic [2:0] {
		REG_IDENTIFY_PERIOD  = 3'd0,
		REG_IDENTIFY_TOGGLES = 3'd1,
		REG_DISPATCH_PERIOD  = 3'd2,
		REG_DISPATCH_TOGGLES = 3'd3,
		REG_ALARM_PERIOD     = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_HAZARD   = 2'd1,
		ACT_IDENTIFY = 2'd2,
		ACT_DISPATCH = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PAT_NONE     = 2'd0,
		PAT_IDENTIFY = 2'd1,
		PAT_DISPATCH = 2'd2
	} pattern_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] identify_period;
		logic [COUNT_W-1:0]  identify_toggles;
		logic [PERIOD_W-1:0] dispatch_period;
		logic [COUNT_W-1:0]  dispatch_toggles;
		logic [PERIOD_W-1:0] alarm_period;
	} cfg_t;

	typedef struct packed {
		logic     led;
		logic     buzzer;
		pattern_t pattern;
		logic     hazard;
	} res_t;

endpackage

// ===== rtl/core/lbps_cfg.sv =====
// Configuration register file with APB-style access.
module lbps_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lbps_pkg::ADDR_W-1:0]  paddr,
	input  logic [lbps_pkg::DATA_W-1:0]  pwdata,
	output logic [lbps_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output lbps_pkg::cfg_t               cfg
);

	lbps_pkg::cfg_t     cfg_q;
	logic               wr_en;
	lbps_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = lbps_pkg::reg_idx_t'(paddr[lbps_pkg::ADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.identify_period  <= lbps_pkg::RST_IDENTIFY_PERIOD;
			cfg_q.identify_toggles <= lbps_pkg::RST_IDENTIFY_TOGGLES;
			cfg_q.dispatch_period  <= lbps_pkg::RST_DISPATCH_PERIOD;
			cfg_q.dispatch_toggles <= lbps_pkg::RST_DISPATCH_TOGGLES;
			cfg_q.alarm_period     <= lbps_pkg::RST_ALARM_PERIOD;
		end else if (wr_en) begin
			unique case (idx)
				lbps_pkg::REG_IDENTIFY_PERIOD:
					cfg_q.identify_period <= pwdata[lbps_pkg::PERIOD_W-1:0];
				lbps_pkg::REG_IDENTIFY_TOGGLES:
					cfg_q.identify_toggles <= pwdata[lbps_pkg::COUNT_W-1:0];
				lbps_pkg::REG_DISPATCH_PERIOD:
					cfg_q.dispatch_period <= pwdata[lbps_pkg::PERIOD_W-1:0];
				lbps_pkg::REG_DISPATCH_TOGGLES:
					cfg_q.dispatch_toggles <= pwdata[lbps_pkg::COUNT_W-1:0];
				lbps_pkg::REG_ALARM_PERIOD:
					cfg_q.alarm_period <= pwdata[lbps_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			lbps_pkg::REG_IDENTIFY_PERIOD:
				prdata[lbps_pkg::PERIOD_W-1:0] = cfg_q.identify_period;
			lbps_pkg::REG_IDENTIFY_TOGGLES:
				prdata[lbps_pkg::COUNT_W-1:0] = cfg_q.identify_toggles;
			lbps_pkg::REG_DISPATCH_PERIOD:
				prdata[lbps_pkg::PERIOD_W-1:0] = cfg_q.dispatch_period;
			lbps_pkg::REG_DISPATCH_TOGGLES:
				prdata[lbps_pkg::COUNT_W-1:0] = cfg_q.dispatch_toggles;
			lbps_pkg::REG_ALARM_PERIOD:
				prdata[lbps_pkg::PERIOD_W-1:0] = cfg_q.alarm_period;
			default: prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/lbps_step.sv =====
// Pattern state registers and the per-item update logic.
`include "led_buzzer_pattern_sequencer_assert.svh"
module lbps_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  lbps_pkg::action_t   action,
	input  logic                hazard_on,
	input  lbps_pkg::cfg_t      cfg,
	output lbps_pkg::res_t      res_next
);

	typedef struct packed {
		lbps_pkg::pattern_t                 mode;
		logic                               phase;
		logic [lbps_pkg::PERIOD_W-1:0]      elapsed;
		logic [lbps_pkg::COUNT_W-1:0]       toggles;
		logic                               hazard;
		logic                               led;
		logic                               buzzer;
	} st_t;

	st_t                           st_q;
	st_t                           st_d;
	logic [lbps_pkg::PERIOD_W-1:0] elapsed_inc;
	logic [lbps_pkg::COUNT_W-1:0]  toggles_inc;

	assign elapsed_inc = (st_q.elapsed == lbps_pkg::ELAPSED_MAX) ? st_q.elapsed
	                     : st_q.elapsed + 1'b1;
	assign toggles_inc = st_q.toggles + 1'b1;

	always_comb begin
		st_d = st_q;
		unique case (action)
			lbps_pkg::ACT_TICK: begin
				st_d.elapsed = elapsed_inc;
				case (st_q.mode)
					lbps_pkg::PAT_IDENTIFY: begin
						if (elapsed_inc >= cfg.identify_period) begin
							st_d.elapsed = '0;
							st_d.phase   = ~st_q.phase;
							st_d.led     = ~st_q.phase;
							st_d.toggles = toggles_inc;
							if (toggles_inc >= cfg.identify_toggles) begin
								st_d.mode = lbps_pkg::PAT_NONE;
								st_d.led  = 1'b0;
							end
						end
					end
					lbps_pkg::PAT_DISPATCH: begin
						if (elapsed_inc >= cfg.dispatch_period) begin
							st_d.elapsed = '0;
							st_d.phase   = ~st_q.phase;
							st_d.led     = ~st_q.phase;
							st_d.buzzer  = ~st_q.phase;
							st_d.toggles = toggles_inc;
							if (toggles_inc >= cfg.dispatch_toggles) begin
								st_d.mode   = lbps_pkg::PAT_NONE;
								st_d.led    = 1'b0;
								st_d.buzzer = st_q.hazard;
							end
						end
					end
					default: begin
						if (!st_q.hazard) begin
							st_d.buzzer = 1'b0;
						end else if (elapsed_inc >= cfg.alarm_period) begin
							st_d.elapsed = '0;
							st_d.phase   = ~st_q.phase;
							st_d.buzzer  = ~st_q.phase;
						end
					end
				endcase
			end
			lbps_pkg::ACT_HAZARD: begin
				st_d.hazard = hazard_on;
				if (!hazard_on && st_q.mode != lbps_pkg::PAT_IDENTIFY
				    && st_q.mode != lbps_pkg::PAT_DISPATCH) begin
					st_d.buzzer = 1'b0;
				end
			end
			lbps_pkg::ACT_IDENTIFY: begin
				st_d.mode    = lbps_pkg::PAT_IDENTIFY;
				st_d.elapsed = '0;
				st_d.toggles = '0;
				st_d.phase   = 1'b1;
				st_d.led     = 1'b1;
				st_d.buzzer  = 1'b0;
			end
			lbps_pkg::ACT_DISPATCH: begin
				st_d.mode    = lbps_pkg::PAT_DISPATCH;
				st_d.elapsed = '0;
				st_d.toggles = '0;
				st_d.phase   = 1'b1;
				st_d.led     = 1'b1;
				st_d.buzzer  = 1'b1;
			end
			default: st_d = st_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (en) begin
			st_q <= st_d;
		end
	end

	assign res_next.led     = st_d.led;
	assign res_next.buzzer  = st_d.buzzer;
	assign res_next.pattern = st_d.mode;
	assign res_next.hazard  = st_d.hazard;

	// idle with no hazard keeps the buzzer quiet
	`LBPS_ASSERT_IMPLY(a_idle_quiet, clk, arst_n,
		st_q.mode == lbps_pkg::PAT_NONE && !st_q.hazard, !st_q.buzzer)
	`LBPS_ASSERT_NEXT(a_dispatch_start, clk, arst_n,
		en && action == lbps_pkg::ACT_DISPATCH,
		st_q.mode == lbps_pkg::PAT_DISPATCH && st_q.led && st_q.buzzer && st_q.phase)
	`LBPS_ASSERT_NEXT(a_hold_when_idle, clk, arst_n, !en, $stable(st_q))

endmodule

// ===== rtl/core/led_buzzer_pattern_sequencer.sv =====
// Top level: input register, pattern update and result register.
// An item's result is valid once the item has passed through the input register and the
// pattern update has loaded the result register; a stalled result keeps it in the input register.
// One item per cycle is taken while results are consumed; the single result
// register sets this, and a stalled result stops the input register only once full.
// Reset (arst_n low, asynchronous) clears all pattern state, empties both registers
// and restores the configuration registers to their default values.
`include "led_buzzer_pattern_sequencer_assert.svh"
module led_buzzer_pattern_sequencer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lbps_pkg::ADDR_W-1:0]  paddr,
	input  logic [lbps_pkg::DATA_W-1:0]  pwdata,
	output logic [lbps_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [1:0]                   action,
	input  logic                         hazard_on,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic                         led_level,
	output logic                         buzzer_level,
	output logic [1:0]                   active_pattern,
	output logic                         hazard_active
);

	lbps_pkg::cfg_t    cfg;
	lbps_pkg::res_t    res_next;
	lbps_pkg::res_t    res_q;
	lbps_pkg::action_t action_s1;
	logic              hazard_on_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic              advance;

	// the update runs when the input register holds an item and the result slot frees
	assign advance    = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	lbps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lbps_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.action    (action_s1),
		.hazard_on (hazard_on_s1),
		.cfg       (cfg),
		.res_next  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			action_s1    <= lbps_pkg::action_t'(action);
			hazard_on_s1 <= hazard_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result_valid   = out_valid_q;
	assign led_level      = res_q.led;
	assign buzzer_level   = res_q.buzzer;
	assign active_pattern = res_q.pattern;
	assign hazard_active  = res_q.hazard;

	`LBPS_ASSERT_NEXT(a_advance_fills, clk, arst_n, advance, out_valid_q)
	`LBPS_ASSERT_IMPLY(a_full_blocks, clk, arst_n,
		valid_s1 && out_valid_q && !result_ready, !item_ready)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the LED and buzzer pattern sequencer.
`timescale 1ns / 1ps
module tb_top;

	typedef struct {
		lbps_pkg::action_t act;
		bit                hz;
	} cmd_t;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          psel         = 1'b0;
	logic                          penable      = 1'b0;
	logic                          pwrite       = 1'b0;
	logic [lbps_pkg::ADDR_W-1:0]   paddr        = '0;
	logic [lbps_pkg::DATA_W-1:0]   pwdata       = '0;
	logic [lbps_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          item_valid   = 1'b0;
	logic                          item_ready;
	logic [1:0]                    action       = lbps_pkg::ACT_TICK;
	logic                          hazard_on    = 1'b0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic                          led_level;
	logic                          buzzer_level;
	logic [1:0]                    active_pattern;
	logic                          hazard_active;

	led_buzzer_pattern_sequencer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.action         (action),
		.hazard_on      (hazard_on),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.led_level      (led_level),
		.buzzer_level   (buzzer_level),
		.active_pattern (active_pattern),
		.hazard_active  (hazard_active)
	);

	// predicted block state
	lbps_pkg::cfg_t     cfg_shadow  = '{lbps_pkg::RST_IDENTIFY_PERIOD,
	                                    lbps_pkg::RST_IDENTIFY_TOGGLES,
	                                    lbps_pkg::RST_DISPATCH_PERIOD,
	                                    lbps_pkg::RST_DISPATCH_TOGGLES,
	                                    lbps_pkg::RST_ALARM_PERIOD};
	lbps_pkg::pattern_t run_mode    = lbps_pkg::PAT_NONE;
	bit                 blink_phase = 1'b0;
	bit [15:0]          ms_count    = '0;
	bit [5:0]           flips       = '0;
	bit                 alarm_flag  = 1'b0;
	bit                 led_q       = 1'b0;
	bit                 buzz_q      = 1'b0;

	cmd_t               pending_items[$];
	lbps_pkg::res_t     levels_due[$];
	cmd_t               next_item;
	lbps_pkg::res_t     want;
	bit                 src_steady  = 1'b0;
	bit                 sink_steady = 1'b0;
	bit                 hold_off    = 1'b0;
	int unsigned        items_queued  = 0;
	int unsigned        items_offered = 0;
	int unsigned        items_taken   = 0;
	int unsigned        err_count     = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic lbps_pkg::res_t pattern_step(lbps_pkg::action_t act, bit hz);
		lbps_pkg::res_t r;
		case (act)
			lbps_pkg::ACT_TICK: begin
				if (ms_count != 16'hFFFF)
					ms_count++;
				if (run_mode == lbps_pkg::PAT_IDENTIFY) begin
					if (ms_count >= cfg_shadow.identify_period) begin
						ms_count = '0;
						blink_phase = ~blink_phase;
						led_q = blink_phase;
						flips++;
						if (flips >= cfg_shadow.identify_toggles) begin
							run_mode = lbps_pkg::PAT_NONE;
							led_q = 1'b0;
						end
					end
				end else if (run_mode == lbps_pkg::PAT_DISPATCH) begin
					if (ms_count >= cfg_shadow.dispatch_period) begin
						ms_count = '0;
						blink_phase = ~blink_phase;
						led_q = blink_phase;
						buzz_q = blink_phase;
						flips++;
						if (flips >= cfg_shadow.dispatch_toggles) begin
							run_mode = lbps_pkg::PAT_NONE;
							led_q = 1'b0;
							buzz_q = alarm_flag;
						end
					end
				end else if (alarm_flag) begin
					if (ms_count >= cfg_shadow.alarm_period) begin
						ms_count = '0;
						blink_phase = ~blink_phase;
						buzz_q = blink_phase;
					end
				end else begin
					buzz_q = 1'b0;
				end
			end
			lbps_pkg::ACT_HAZARD: begin
				alarm_flag = hz;
				if (!hz && run_mode == lbps_pkg::PAT_NONE)
					buzz_q = 1'b0;
			end
			default: begin
				run_mode = (act == lbps_pkg::ACT_IDENTIFY) ? lbps_pkg::PAT_IDENTIFY
				                                           : lbps_pkg::PAT_DISPATCH;
				ms_count = '0;
				flips = '0;
				blink_phase = 1'b1;
				led_q = 1'b1;
				buzz_q = (act == lbps_pkg::ACT_DISPATCH);
			end
		endcase
		r.led = led_q;
		r.buzzer = buzz_q;
		r.pattern = run_mode;
		r.hazard = alarm_flag;
		return r;
	endfunction

	task automatic flag_error(string msg);
		if (err_count < 50)
			$display("%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// item source; the offered item is gone once the monitor has counted it
	always @(negedge clk) begin
		if (!item_valid || items_taken == items_offered) begin
			if (arst_n && pending_items.size() != 0 &&
			    (src_steady || $urandom_range(99) >= 17)) begin
				next_item = pending_items.pop_front();
				item_valid <= 1'b1;
				action <= next_item.act;
				hazard_on <= next_item.hz;
				items_offered++;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result sink
	always @(negedge clk) begin
		if (hold_off)
			result_ready <= 1'b0;
		else
			result_ready <= sink_steady || ($urandom_range(99) >= 17);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (levels_due.size() == 0) begin
					flag_error("result with no item outstanding");
				end else begin
					want = levels_due.pop_front();
					if (led_level !== want.led)
						flag_error($sformatf("led_level got %b want %b", led_level, want.led));
					if (buzzer_level !== want.buzzer)
						flag_error($sformatf("buzzer_level got %b want %b",
							buzzer_level, want.buzzer));
					if (active_pattern !== want.pattern)
						flag_error($sformatf("active_pattern got %0d want %0d",
							active_pattern, want.pattern));
					if (hazard_active !== want.hazard)
						flag_error($sformatf("hazard_active got %b want %b",
							hazard_active, want.hazard));
				end
			end
			if (item_valid && item_ready) begin
				levels_due.push_back(pattern_step(lbps_pkg::action_t'(action), hazard_on));
				items_taken++;
			end
		end
	end

	task automatic queue_item(lbps_pkg::action_t act, bit hz);
		cmd_t c;
		c.act = act;
		c.hz = hz;
		pending_items.push_back(c);
		items_queued++;
	endtask

	task automatic queue_ticks(int unsigned n);
		repeat (n) queue_item(lbps_pkg::ACT_TICK, 1'($urandom_range(1)));
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || levels_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(lbps_pkg::reg_idx_t idx, int unsigned val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			lbps_pkg::REG_IDENTIFY_PERIOD:  cfg_shadow.identify_period  = val[15:0];
			lbps_pkg::REG_IDENTIFY_TOGGLES: cfg_shadow.identify_toggles = val[5:0];
			lbps_pkg::REG_DISPATCH_PERIOD:  cfg_shadow.dispatch_period  = val[15:0];
			lbps_pkg::REG_DISPATCH_TOGGLES: cfg_shadow.dispatch_toggles = val[5:0];
			lbps_pkg::REG_ALARM_PERIOD:     cfg_shadow.alarm_period     = val[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(int unsigned ip, int unsigned it, int unsigned dp,
	                          int unsigned dt, int unsigned ap);
		wait_drained();
		reg_write(lbps_pkg::REG_IDENTIFY_PERIOD, ip);
		reg_write(lbps_pkg::REG_IDENTIFY_TOGGLES, it);
		reg_write(lbps_pkg::REG_DISPATCH_PERIOD, dp);
		reg_write(lbps_pkg::REG_DISPATCH_TOGGLES, dt);
		reg_write(lbps_pkg::REG_ALARM_PERIOD, ap);
	endtask

	// mostly patterns of random length and content, some alarm runs, some noise
	task automatic random_items(int unsigned n);
		int unsigned done;
		int unsigned span;
		int unsigned pick;
		bit          disp;
		done = 0;
		while (done < n) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				disp = $urandom_range(1);
				queue_item(disp ? lbps_pkg::ACT_DISPATCH : lbps_pkg::ACT_IDENTIFY,
				           1'($urandom_range(1)));
				span = disp ? cfg_shadow.dispatch_period * cfg_shadow.dispatch_toggles
				            : cfg_shadow.identify_period * cfg_shadow.identify_toggles;
				span = $urandom_range(span + 4);
				repeat (span) begin
					if ($urandom_range(99) < 8)
						queue_item(lbps_pkg::ACT_HAZARD, 1'($urandom_range(1)));
					else
						queue_item(lbps_pkg::ACT_TICK, 1'($urandom_range(1)));
				end
				done += span + 1;
			end else if (pick < 82) begin
				queue_item(lbps_pkg::ACT_HAZARD, 1'b1);
				span = $urandom_range(3 * cfg_shadow.alarm_period + 2, 1);
				queue_ticks(span);
				done += span + 1;
			end else begin
				queue_item(lbps_pkg::action_t'($urandom_range(3)), 1'($urandom_range(1)));
				done++;
			end
		end
	endtask

	// long receiver stall while the source keeps offering
	initial begin
		wait (items_taken >= 300);
		hold_off = 1'b1;
		repeat (400) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration: events, restarts and hazard changes in and out of patterns
		queue_item(lbps_pkg::ACT_TICK, 1'b1);
		queue_item(lbps_pkg::ACT_HAZARD, 1'b1);
		queue_item(lbps_pkg::ACT_TICK, 1'b0);
		queue_item(lbps_pkg::ACT_HAZARD, 1'b0);
		queue_item(lbps_pkg::ACT_IDENTIFY, 1'b1);
		queue_item(lbps_pkg::ACT_TICK, 1'b0);
		queue_item(lbps_pkg::ACT_HAZARD, 1'b1);
		queue_item(lbps_pkg::ACT_DISPATCH, 1'b0);
		queue_item(lbps_pkg::ACT_IDENTIFY, 1'b0);
		queue_item(lbps_pkg::ACT_HAZARD, 1'b0);
		queue_item(lbps_pkg::ACT_DISPATCH, 1'b1);
		queue_item(lbps_pkg::ACT_HAZARD, 1'b1);
		queue_ticks(90);

		set_config(65535, 63, 65535, 63, 65535);
		queue_item(lbps_pkg::ACT_IDENTIFY, 1'b1);
		queue_ticks(3);
		queue_item(lbps_pkg::ACT_DISPATCH, 1'b0);
		queue_ticks(3);
		queue_item(lbps_pkg::ACT_HAZARD, 1'b0);

		// periods of one, no idling either side
		set_config(1, 63, 1, 63, 1);
		src_steady = 1'b1;
		sink_steady = 1'b1;
		queue_item(lbps_pkg::ACT_IDENTIFY, 1'b0);
		queue_ticks(64);
		queue_item(lbps_pkg::ACT_DISPATCH, 1'b1);
		queue_ticks(64);
		queue_item(lbps_pkg::ACT_HAZARD, 1'b1);
		queue_ticks(5);
		queue_item(lbps_pkg::ACT_IDENTIFY, 1'b1);
		queue_ticks(2);
		wait_drained();
		src_steady = 1'b0;
		sink_steady = 1'b0;

		// zero period acts every tick, zero limit ends at the first toggle
		set_config(0, 0, 0, 0, 0);
		queue_item(lbps_pkg::ACT_IDENTIFY, 1'b0);
		queue_ticks(2);
		queue_item(lbps_pkg::ACT_DISPATCH, 1'b0);
		queue_ticks(2);
		queue_item(lbps_pkg::ACT_HAZARD, 1'b1);
		queue_ticks(3);
		queue_item(lbps_pkg::ACT_HAZARD, 1'b0);
		queue_ticks(2);

		repeat (3) begin
			set_config($urandom_range(6, 1), $urandom_range(12, 1), $urandom_range(6, 1),
			           $urandom_range(12, 1), $urandom_range(6, 1));
			random_items(250);
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lbps_pkg.sv
rtl/core/lbps_cfg.sv
rtl/core/lbps_step.sv
rtl/core/led_buzzer_pattern_sequencer.sv
tb/tb_top.sv
